[src/hbsfc_pkg.sv]
// Package for the half / bfloat16 / single format converter.
// Holds the action codes, format constants, pipeline stage types and a small helper.
// No dependencies.
package hbsfc_pkg;

    typedef enum logic [1:0] {
        ACT_H2S = 2'd0,
        ACT_S2H = 2'd1,
        ACT_B2S = 2'd2,
        ACT_S2B = 2'd3
    } action_t;

    localparam logic [4:0]        H_EXP_ALL    = 5'h1F;
    localparam logic [7:0]        S_EXP_ALL    = 8'hFF;
    localparam logic [7:0]        H2S_BIAS_ADJ = 8'd112;
    localparam logic [7:0]        H2S_SUB_EXP  = 8'd113;
    localparam logic signed [8:0] S2H_BIAS_ADJ = 9'sd112;
    localparam logic signed [8:0] S2H_TINY_MIN = -9'sd10;
    localparam logic signed [8:0] S2H_EXP_MAX  = 9'sd31;
    localparam logic [9:0]        H_QUIET      = 10'h200;
    localparam logic [14:0]       H_INF_MAG    = 15'h7C00;
    localparam logic [31:0]       BF_ROUND     = 32'h0000_7FFF;
    localparam logic [15:0]       BF_QUIET     = 16'h0040;
    localparam logic [31:0]       S_NAN_MASK   = 32'h7FC0_0000;
    localparam logic [31:0]       S_SNAN_EXP   = 32'h7F80_0000;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

    typedef struct packed {
        action_t            act;
        logic [31:0]        operand;
        logic [3:0]         h_shift;
        logic signed [8:0]  s_exp;
        logic               s_tiny;
        logic               s_sub;
        logic               s_big;
        logic [3:0]         s_rsh;
        logic               b_snan;
    } stage1_t;

    typedef struct packed {
        logic [31:0] base;
        logic        rnd;
    } stage2_t;

    // Normalizing shift for a half subnormal fraction: one more than the
    // number of leading zeros in the 10-bit field.
    function automatic logic [3:0] half_norm_shift(input logic [9:0] frac);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (frac[i])
            begin
                n = 4'(10 - i);
            end
        end
        return n;
    endfunction

endpackage

[src/half_bfloat_single_format_converter_unit.sv]
// Top level of the half / bfloat16 / single format converter.
// Depends on hbsfc_pkg and hbsfc_core; holds the stream handshake and stage valid bits.
//
// The unit takes one request per clock when the output side is not stalled
// and returns the results in order. The three register stages (classify,
// shift and align, round and pack) each hold one request, so up to three
// requests are in flight and a stall on the output backs up through the
// stages without losing or repeating anything.
module half_bfloat_single_format_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] converted
);
    import hbsfc_pkg::*;

    logic     v1_reg;
    logic     v2_reg;
    logic     v3_reg;
    logic     rdy1;
    logic     rdy2;
    logic     rdy3;
    pipe_en_t en;

    assign rdy3 = !v3_reg || m_axis_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.s1 = rdy1 && s_axis_tvalid;
    assign en.s2 = rdy2 && v1_reg;
    assign en.s3 = rdy3 && v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    hbsfc_core u_core (
        .clk        (clk),
        .en         (en),
        .in_action  (action_t'(s_axis_tuser)),
        .in_operand (s_axis_tdata),
        .converted  (m_axis_tdata)
    );

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v3_reg;

    logic in_acc;
    logic out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input blocked while a stage is empty");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> v1_reg)
        else $error("accepted request not held in first stage");

    a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy3) |=> v2_reg)
        else $error("second stage request dropped during stall");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
        ($countones({v1_reg, v2_reg, v3_reg}) + int'($past(out_acc))
         == $past($countones({v1_reg, v2_reg, v3_reg})) + int'($past(in_acc))))
        else $error("request count in flight does not match handshakes");

endmodule

[src/hbsfc_core.sv]
// Three-stage datapath of the format converter: classify, shift/align, round/pack.
// Depends on hbsfc_pkg; stage enables come from the handshake control in the top level.
module hbsfc_core (
    input  logic                clk,
    input  hbsfc_pkg::pipe_en_t en,
    input  hbsfc_pkg::action_t  in_action,
    input  logic [31:0]         in_operand,
    output logic [31:0]         converted
);
    import hbsfc_pkg::*;

    stage1_t     s1_reg;
    stage1_t     s1_next;
    stage2_t     s2_reg;
    stage2_t     s2_next;
    logic [31:0] converted_reg;
    logic [31:0] converted_next;

    always_comb
    begin
        s1_next         = '0;
        s1_next.act     = in_action;
        s1_next.operand = in_operand;
        s1_next.h_shift = half_norm_shift(in_operand[9:0]);
        s1_next.s_exp   = $signed({1'b0, in_operand[30:23]}) - S2H_BIAS_ADJ;
        s1_next.s_tiny  = s1_next.s_exp < S2H_TINY_MIN;
        s1_next.s_sub   = s1_next.s_exp <= 9'sd0;
        s1_next.s_big   = s1_next.s_exp >= S2H_EXP_MAX;
        s1_next.s_rsh   = 4'(9'sd1 - s1_next.s_exp);
        s1_next.b_snan  = ((in_operand & S_NAN_MASK) == S_SNAN_EXP)
                          && (in_operand[22:0] != 23'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_reg <= s1_next;
        end
    end

    logic [31:0] op;
    logic [9:0]  h_frac;
    logic [4:0]  h_exp;
    logic [9:0]  h_norm;
    logic [23:0] s_mant;
    logic [31:0] b_sum;

    assign op     = s1_reg.operand;
    assign h_frac = op[9:0];
    assign h_exp  = op[14:10];
    assign h_norm = h_frac << s1_reg.h_shift;
    assign s_mant = {1'b1, op[22:0]} >> s1_reg.s_rsh;
    assign b_sum  = op + BF_ROUND + {31'd0, op[16]};

    always_comb
    begin
        s2_next = '0;
        case (s1_reg.act)
            ACT_H2S:
            begin
                if (h_exp == 5'd0)
                begin
                    if (h_frac == 10'd0)
                    begin
                        s2_next.base = {op[15], 31'd0};
                    end
                    else
                    begin
                        s2_next.base = {op[15], H2S_SUB_EXP - {4'd0, s1_reg.h_shift},
                                        h_norm, 13'd0};
                    end
                end
                else if (h_exp == H_EXP_ALL)
                begin
                    s2_next.base = {op[15], S_EXP_ALL, h_frac, 13'd0};
                end
                else
                begin
                    s2_next.base = {op[15], {3'd0, h_exp} + H2S_BIAS_ADJ, h_frac, 13'd0};
                end
            end
            ACT_S2H:
            begin
                if (s1_reg.s_tiny)
                begin
                    s2_next.base = {16'd0, op[31], 15'd0};
                end
                else if (s1_reg.s_sub)
                begin
                    s2_next.base = {16'd0, op[31], 4'd0, s_mant[23:13]};
                    s2_next.rnd  = s_mant[12];
                end
                else if (s1_reg.s_big)
                begin
                    if ((op[30:23] == S_EXP_ALL) && (op[22:0] != 23'd0))
                    begin
                        s2_next.base = {16'd0, op[31], H_EXP_ALL, op[22:13] | H_QUIET};
                    end
                    else
                    begin
                        s2_next.base = {16'd0, op[31], H_INF_MAG};
                    end
                end
                else
                begin
                    s2_next.base = {16'd0, op[31], s1_reg.s_exp[4:0], op[22:13]};
                    s2_next.rnd  = op[12];
                end
            end
            ACT_B2S:
            begin
                s2_next.base = {op[15:0], 16'd0};
            end
            ACT_S2B:
            begin
                if (s1_reg.b_snan)
                begin
                    s2_next.base = {16'd0, op[31:16] | BF_QUIET};
                end
                else
                begin
                    s2_next.base = {16'd0, b_sum[31:16]};
                end
            end
            default:
            begin
                s2_next.base = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_reg <= s2_next;
        end
    end

    // A rounding carry out of the half fraction lands in the exponent, and
    // from the largest finite half it lands exactly on infinity.
    assign converted_next = s2_reg.base + {31'd0, s2_reg.rnd};

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            converted_reg <= converted_next;
        end
    end

    assign converted = converted_reg;

endmodule
